@@ src/lg_pkg.sv @@
`default_nettype none

package lg_pkg;

  localparam int LG_COLUMNS = 12;
  localparam int LG_ROWS = 25;

  localparam logic [7:0] MAX_GEN_RESET = 8'd150;
  localparam int LIVE_MAX = 511;

  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_ADVANCE = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam int APB_ADDR_W = 3;
  localparam logic [APB_ADDR_W-1:0] ADDR_MAX_GEN = 3'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } lg_state_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] cell_column;
    logic [4:0] cell_row;
    logic       cell_value;
  } lg_in_t;

  typedef struct packed {
    logic       cell_out;
    logic [8:0] live_count;
    logic [7:0] generation;
    logic       restart;
  } lg_out_t;

  typedef struct packed {
    logic shift;
    logic write;
    logic value;
  } lg_ctl_t;

  // Next state of one cell from its 3x3 neighborhood; the middle bit of
  // the center triple is the cell itself.
  function automatic logic lg_live_next(input logic [2:0] above,
                                        input logic [2:0] center,
                                        input logic [2:0] below);
    logic [3:0] n;
    n = 4'(above[0]) + 4'(above[1]) + 4'(above[2]) + 4'(center[0]) +
        4'(center[2]) + 4'(below[0]) + 4'(below[1]) + 4'(below[2]);
    return (n == BIRTH_COUNT) || ((n == SURVIVE_COUNT) && center[1]);
  endfunction

endpackage

`default_nettype wire

@@ src/life_grid_generation_step.sv @@
`default_nettype none

// Game of Life grid of GRID_ROWS by GRID_COLUMNS cells. Each input word
// writes one cell, reads one cell, advances the whole grid one generation
// (cells beyond the edges count as dead) or, in the unused mode, changes
// nothing; every word returns one result word with the live-cell count
// and the generation number. The grid is a chain of row cells. An advance
// rotates the chain once, one row per cycle through a single rule unit,
// in the run state and then the finish state; a write, a read or an unused
// mode goes straight to the finish state. One word is in work at a time,
// and the next one is accepted while the previous result still waits at
// the output register. max_generations sits at APB address 0.
module life_grid_generation_step #(
  parameter int GRID_COLUMNS = lg_pkg::LG_COLUMNS,
  parameter int GRID_ROWS = lg_pkg::LG_ROWS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire lg_pkg::lg_in_t                in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output lg_pkg::lg_out_t                    out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lg_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);
  import lg_pkg::*;

  localparam int COLS = GRID_COLUMNS;
  localparam int ROWS = GRID_ROWS;
  localparam int ROW_W = $clog2(ROWS);
  localparam int CNT_W = $clog2(ROWS * COLS + 1);
  localparam int POP_W = $clog2(COLS + 1);

  lg_state_t state, state_next;

  lg_in_t           cmd;
  logic [7:0]       max_gen;
  logic [7:0]       gen;
  logic [CNT_W-1:0] live_total;
  logic [ROW_W-1:0] row_idx;
  logic [COLS-1:0]  prev_row;

  logic             in_accept;
  logic             slot_free;
  logic             load_out;
  logic             last_row;
  logic             on_grid;
  logic             rd_bit;
  logic             restart;
  logic [8:0]       gen_inc;
  logic [8:0]       live_sat;
  lg_ctl_t          ctl;

  logic [COLS-1:0]  col_mask;
  logic [COLS-1:0]  rows [ROWS];
  logic [ROWS-1:0]  hit;
  logic [ROWS-1:0]  bits;
  logic [COLS-1:0]  below;
  logic [COLS-1:0]  new_row;
  logic [POP_W-1:0] new_pop;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MAX_GEN) ? {24'd0, max_gen} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_gen <= MAX_GEN_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_MAX_GEN)) begin
      max_gen <= pwdata[7:0];
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign last_row = (row_idx == ROW_W'(ROWS - 1));

  assign on_grid = (32'(cmd.cell_column) < COLS) && (32'(cmd.cell_row) < ROWS);
  assign col_mask = on_grid ? (COLS'(1) << cmd.cell_column) : '0;

  genvar gi;
  generate
    for (gi = 0; gi < ROWS; gi++) begin : g_row
      assign hit[gi] = on_grid && (32'(cmd.cell_row) == gi);
      if (gi == ROWS - 1) begin : g_tail
        lg_cell #(.COLS(COLS)) u_cell (
          .clk(clk), .rst(rst), .ctl(ctl), .hit(hit[gi]), .col_mask(col_mask),
          .shift_in(new_row), .row_out(rows[gi]), .bit_out(bits[gi])
        );
      end else begin : g_body
        lg_cell #(.COLS(COLS)) u_cell (
          .clk(clk), .rst(rst), .ctl(ctl), .hit(hit[gi]), .col_mask(col_mask),
          .shift_in(rows[gi+1]), .row_out(rows[gi]), .bit_out(bits[gi])
        );
      end
    end
  endgenerate

  assign rd_bit = |bits;
  assign below = last_row ? '0 : rows[1];

  lg_rule #(.COLS(COLS)) u_rule (
    .above(prev_row),
    .center(rows[0]),
    .below(below),
    .next_row(new_row),
    .pop(new_pop)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = (in_data.mode == MODE_ADVANCE) ? ST_RUN : ST_FINISH;
        end
      end
      ST_RUN: begin
        if (last_row) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.shift = (state == ST_RUN);
    ctl.write = 1'b0;
    ctl.value = cmd.cell_value;
    load_out = 1'b0;
    case (state)
      ST_FINISH: begin
        load_out = slot_free;
        ctl.write = slot_free && (cmd.mode == MODE_WRITE);
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  assign gen_inc = {1'b0, gen} + 9'd1;
  assign restart = (gen_inc > {1'b0, max_gen}) || (live_total == '0);
  assign live_sat = (32'(live_total) > LIVE_MAX) ? 9'(LIVE_MAX) : 9'(live_total);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      gen <= 8'd0;
      live_total <= '0;
      row_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_accept && (in_data.mode == MODE_ADVANCE)) begin
        live_total <= '0;
      end else if (state == ST_RUN) begin
        live_total <= live_total + CNT_W'(new_pop);
      end else if (ctl.write) begin
        if (cmd.cell_value && on_grid && !rd_bit) begin
          live_total <= live_total + CNT_W'(1);
        end else if (!cmd.cell_value && rd_bit) begin
          live_total <= live_total - CNT_W'(1);
        end
      end
      if (state == ST_RUN) begin
        row_idx <= last_row ? '0 : row_idx + ROW_W'(1);
      end
      if (load_out && (cmd.mode == MODE_ADVANCE)) begin
        gen <= restart ? 8'd0 : gen_inc[7:0];
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd <= in_data;
      prev_row <= '0;
    end else if (state == ST_RUN) begin
      prev_row <= rows[0];
    end
    if (load_out) begin
      out_data.cell_out <= (cmd.mode == MODE_READ) && rd_bit;
      if (cmd.mode == MODE_ADVANCE) begin
        out_data.live_count <= live_sat;
        out_data.generation <= restart ? 8'd0 : gen_inc[7:0];
        out_data.restart <= restart;
      end else if (cmd.mode == MODE_WRITE) begin
        out_data.generation <= gen;
        out_data.restart <= 1'b0;
        if (cmd.cell_value && on_grid && !rd_bit) begin
          out_data.live_count <= (32'(live_total) + 1 > LIVE_MAX) ?
                                 9'(LIVE_MAX) : 9'(live_total + CNT_W'(1));
        end else if (!cmd.cell_value && rd_bit) begin
          out_data.live_count <= (32'(live_total) - 1 > LIVE_MAX) ?
                                 9'(LIVE_MAX) : 9'(live_total - CNT_W'(1));
        end else begin
          out_data.live_count <= live_sat;
        end
      end else begin
        out_data.live_count <= live_sat;
        out_data.generation <= gen;
        out_data.restart <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_row_idx_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_RUN) |-> (row_idx == '0))
    else $error("row counter not at zero outside a generation step");

  a_run_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |=> ((state == ST_RUN) || (state == ST_FINISH)))
    else $error("generation step left without finishing");

  a_restart_gen: assert property (@(posedge clk) disable iff (rst)
    (load_out && (cmd.mode == MODE_ADVANCE) && restart) |=> (gen == 8'd0))
    else $error("generation number not cleared on restart");

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    32'(live_total) <= ROWS * COLS)
    else $error("live count exceeds grid size");
`endif

endmodule

`default_nettype wire

@@ src/lg_cell.sv @@
`default_nettype none

module lg_cell #(
  parameter int COLS = lg_pkg::LG_COLUMNS
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire lg_pkg::lg_ctl_t ctl,
  input  wire logic            hit,
  input  wire logic [COLS-1:0] col_mask,
  input  wire logic [COLS-1:0] shift_in,
  output logic      [COLS-1:0] row_out,
  output logic                 bit_out
);
  import lg_pkg::*;

  logic [COLS-1:0] row_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_q <= '0;
    end else if (ctl.shift) begin
      row_q <= shift_in;
    end else if (ctl.write && hit) begin
      row_q <= ctl.value ? (row_q | col_mask) : (row_q & ~col_mask);
    end
  end

  assign row_out = row_q;
  assign bit_out = hit && (|(row_q & col_mask));

endmodule

`default_nettype wire

@@ src/lg_rule.sv @@
`default_nettype none

module lg_rule #(
  parameter int COLS = lg_pkg::LG_COLUMNS,
  localparam int POP_W = $clog2(COLS + 1)
) (
  input  wire logic [COLS-1:0]  above,
  input  wire logic [COLS-1:0]  center,
  input  wire logic [COLS-1:0]  below,
  output logic      [COLS-1:0]  next_row,
  output logic      [POP_W-1:0] pop
);
  import lg_pkg::*;

  logic [COLS+1:0] a_ext;
  logic [COLS+1:0] c_ext;
  logic [COLS+1:0] b_ext;

  assign a_ext = {1'b0, above, 1'b0};
  assign c_ext = {1'b0, center, 1'b0};
  assign b_ext = {1'b0, below, 1'b0};

  always_comb begin
    for (int j = 0; j < COLS; j++) begin
      next_row[j] = lg_live_next(a_ext[j +: 3], c_ext[j +: 3], b_ext[j +: 3]);
    end
  end

  assign pop = POP_W'($countones(next_row));

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lg_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 117;
  localparam int PHASES = 6;

  typedef struct packed {
    lg_in_t  word;
    logic    fixed;
    lg_out_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  lg_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lg_out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [LG_COLUMNS-1:0] grid_q [LG_ROWS];
  int unsigned gen_q = 0;
  int unsigned limit_q = MAX_GEN_RESET;
  lg_out_t pending_results [$];
  int mismatch_count = 0;
  int send_idle_pct = 29;
  int stall_pct = 79;

  life_grid_generation_step i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [8:0] got,
                               input logic [8:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    end
  endtask

  function automatic int unsigned cell_at(input int r, input int c);
    if (r < 0 || r >= LG_ROWS || c < 0 || c >= LG_COLUMNS) begin
      return 0;
    end
    return grid_q[r][c];
  endfunction

  function automatic int unsigned live_total();
    int unsigned n;
    n = 0;
    for (int r = 0; r < LG_ROWS; r++) begin
      for (int c = 0; c < LG_COLUMNS; c++) begin
        n += grid_q[r][c];
      end
    end
    return n;
  endfunction

  function automatic int unsigned grid_advance();
    logic [LG_COLUMNS-1:0] nxt [LG_ROWS];
    int unsigned total;
    int unsigned n;
    total = 0;
    for (int r = 0; r < LG_ROWS; r++) begin
      nxt[r] = '0;
      for (int c = 0; c < LG_COLUMNS; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) begin
              n += cell_at(r + dr, c + dc);
            end
          end
        end
        if (n == 3 || (n == 2 && cell_at(r, c) == 1)) begin
          nxt[r][c] = 1'b1;
          total++;
        end
      end
    end
    grid_q = nxt;
    return total;
  endfunction

  function automatic lg_out_t life_step(input lg_in_t w);
    lg_out_t res;
    bit on_grid;
    int unsigned total;
    int unsigned next_gen;
    res = '0;
    on_grid = (w.cell_column < LG_COLUMNS) && (w.cell_row < LG_ROWS);
    case (w.mode)
      MODE_WRITE: begin
        if (on_grid) begin
          grid_q[w.cell_row][w.cell_column] = w.cell_value;
        end
        total = live_total();
      end
      MODE_ADVANCE: begin
        total = grid_advance();
        next_gen = gen_q + 1;
        if (next_gen > limit_q || total == 0) begin
          next_gen = 0;
          res.restart = 1'b1;
        end
        gen_q = next_gen & 8'hFF;
      end
      default: begin
        if (w.mode == MODE_READ && on_grid) begin
          res.cell_out = grid_q[w.cell_row][w.cell_column];
        end
        total = live_total();
      end
    endcase
    res.live_count = (total > LIVE_MAX) ? 9'(LIVE_MAX) : 9'(total);
    res.generation = 8'(gen_q);
    return res;
  endfunction

  function automatic stim_row_t dir_row(input logic [1:0] mode, input int col, input int r,
                                        input bit val, input bit fixed, input bit cell_bit = 0,
                                        input int live = 0, input int gen = 0,
                                        input bit rs = 0);
    stim_row_t s;
    s.word.mode = mode;
    s.word.cell_column = 4'(col);
    s.word.cell_row = 5'(r);
    s.word.cell_value = val;
    s.fixed = fixed;
    s.want.cell_out = cell_bit;
    s.want.live_count = 9'(live);
    s.want.generation = 8'(gen);
    s.want.restart = rs;
    return s;
  endfunction

  task automatic send_word(input lg_in_t w, input bit fixed = 0,
                           input lg_out_t want = '0);
    lg_out_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    predicted = life_step(w);
    pending_results.push_back(fixed ? want : predicted);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LG_ROWS + 2) @(posedge clk);
  endtask

  task automatic set_limit(input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_MAX_GEN;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== value) begin
      report_mismatch($sformatf("max_generations read %0d, want %0d", prdata[7:0], value));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    limit_q = value;
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : result_check
    lg_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = pending_results.pop_front();
        compare_field("cell_out", 9'(out_data.cell_out), 9'(want.cell_out));
        compare_field("live_count", out_data.live_count, want.live_count);
        compare_field("generation", 9'(out_data.generation), 9'(want.generation));
        compare_field("restart", 9'(out_data.restart), 9'(want.restart));
      end
    end
  end

  initial begin : stimulus
    stim_row_t directed [$];
    lg_in_t w;
    int sent;
    int burst;
    int pick;
    bit paused;
    logic [7:0] limit;

    for (int r = 0; r < LG_ROWS; r++) begin
      grid_q[r] = '0;
    end

    // Reset state first, then the edges of the address fields, then a blinker.
    directed.push_back(dir_row(MODE_READ, 0, 0, 0, 1, 0, 0, 0, 0));
    directed.push_back(dir_row(MODE_UNUSED, 15, 31, 1, 1, 0, 0, 0, 0));
    directed.push_back(dir_row(MODE_ADVANCE, 0, 0, 0, 1, 0, 0, 0, 1));
    directed.push_back(dir_row(MODE_WRITE, 11, 24, 1, 1, 0, 1, 0, 0));
    directed.push_back(dir_row(MODE_WRITE, 12, 0, 1, 1, 0, 1, 0, 0));
    directed.push_back(dir_row(MODE_WRITE, 0, 25, 1, 1, 0, 1, 0, 0));
    directed.push_back(dir_row(MODE_WRITE, 15, 31, 1, 1, 0, 1, 0, 0));
    directed.push_back(dir_row(MODE_READ, 15, 31, 0, 1, 0, 1, 0, 0));
    directed.push_back(dir_row(MODE_READ, 11, 24, 0, 1, 1, 1, 0, 0));
    directed.push_back(dir_row(MODE_READ, 11, 25, 0, 1, 0, 1, 0, 0));
    directed.push_back(dir_row(MODE_WRITE, 0, 0, 1, 1, 0, 2, 0, 0));
    directed.push_back(dir_row(MODE_WRITE, 11, 24, 0, 1, 0, 1, 0, 0));
    directed.push_back(dir_row(MODE_WRITE, 0, 0, 0, 1, 0, 0, 0, 0));
    directed.push_back(dir_row(MODE_WRITE, 5, 10, 1, 1, 0, 1, 0, 0));
    directed.push_back(dir_row(MODE_WRITE, 5, 11, 1, 1, 0, 2, 0, 0));
    directed.push_back(dir_row(MODE_WRITE, 5, 12, 1, 1, 0, 3, 0, 0));
    directed.push_back(dir_row(MODE_ADVANCE, 0, 0, 0, 1, 0, 3, 1, 0));
    directed.push_back(dir_row(MODE_READ, 4, 11, 0, 1, 1, 3, 1, 0));
    directed.push_back(dir_row(MODE_READ, 5, 10, 0, 1, 0, 3, 1, 0));
    directed.push_back(dir_row(MODE_ADVANCE, 0, 0, 0, 1, 0, 3, 2, 0));
    directed.push_back(dir_row(MODE_UNUSED, 5, 11, 1, 1, 0, 3, 2, 0));
    directed.push_back(dir_row(MODE_WRITE, 0, 0, 1, 0));
    directed.push_back(dir_row(MODE_ADVANCE, 0, 0, 0, 0));
    directed.push_back(dir_row(MODE_READ, 0, 0, 0, 0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      send_word(directed[i].word, directed[i].fixed, directed[i].want);
    end

    // With a limit of zero every advance restarts the count.
    wait_drained();
    set_limit(8'd0);
    repeat (3) begin
      send_word(dir_row(MODE_ADVANCE, 3, 7, 1, 0).word);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: limit = 8'd255;
        1: limit = 8'd1;
        2: limit = 8'($urandom_range(12, 2));
        3: limit = 8'd0;
        4: limit = 8'($urandom_range(255, 1));
        default: limit = MAX_GEN_RESET;
      endcase
      set_limit(limit);
      if (ph < 2) begin
        send_idle_pct = 29;
        stall_pct = 79;
      end else if (ph < 4) begin
        send_idle_pct = 79;
        stall_pct = 29;
      end else begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      sent = 0;
      paused = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          burst = $urandom_range(15, 4);
          repeat (burst) begin
            w.mode = ($urandom_range(99) < 80) ? MODE_WRITE : MODE_READ;
            w.cell_column = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                     : 4'($urandom_range(LG_COLUMNS - 1));
            w.cell_row = ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                                  : 5'($urandom_range(LG_ROWS - 1));
            w.cell_value = ($urandom_range(99) < 65);
            send_word(w);
          end
        end else if (pick < 90) begin
          burst = $urandom_range(30, 1);
          repeat (burst) begin
            w = lg_in_t'(12'($urandom));
            w.mode = MODE_ADVANCE;
            send_word(w);
          end
        end else begin
          burst = $urandom_range(3, 1);
          repeat (burst) begin
            send_word(lg_in_t'(12'($urandom)));
          end
        end
        sent += burst;
        if (!paused && sent >= PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1;
        end
      end
    end

    wait_drained();
    repeat (2 * (LG_ROWS + 2)) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
